### sv/smp_pkg.sv
// Package of the segmented memory core: request and response types, codes and memory geometry.
package smp_pkg;

	// Memory geometry.
	localparam int MEM_BYTES = 16384;
	localparam int SEG_BYTES = 4096;
	localparam int MEM_AW    = $clog2(MEM_BYTES);

	// Byte addresses carry one bit beyond 32 so that address plus offset never wraps.
	localparam int BADDR_W = 33;

	localparam logic [BADDR_W-1:0] SEG_END_CODE = BADDR_W'(SEG_BYTES);
	localparam logic [BADDR_W-1:0] SEG_END_DATA = BADDR_W'(2 * SEG_BYTES);
	localparam logic [BADDR_W-1:0] SEG_END_HEAP = BADDR_W'(3 * SEG_BYTES);
	localparam logic [BADDR_W-1:0] STACK_BASE   =
		BADDR_W'((MEM_BYTES >= SEG_BYTES) ? (MEM_BYTES - SEG_BYTES) : 0);
	localparam logic [BADDR_W-1:0] STACK_END    =
		BADDR_W'(((MEM_BYTES >= SEG_BYTES) ? (MEM_BYTES - SEG_BYTES) : 0) + SEG_BYTES);
	localparam logic [BADDR_W-1:0] MEM_END      = BADDR_W'(MEM_BYTES);
	localparam logic [MEM_AW-1:0]  CLR_LAST     = MEM_AW'(MEM_BYTES - 1);

	// Configuration port.
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;
	localparam int PERM_W   = 3;
	localparam int NUM_SEGS = 4;

	localparam logic [PERM_W-1:0] PERM_READ  = 3'b001;
	localparam logic [PERM_W-1:0] PERM_WRITE = 3'b010;

	localparam logic [PERM_W-1:0] PERM_RST_CODE  = 3'd7;
	localparam logic [PERM_W-1:0] PERM_RST_OTHER = 3'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_INVALID   = 2'd1;
	localparam logic [1:0] STAT_VIOLATION = 2'd2;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_QUERY = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACCESS,
		S_QUERY,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t         opcode;
		logic [1:0]  size_code;
		logic [31:0] address;
		logic [63:0] write_data;
		logic [2:0]  query_mask;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [1:0]  status;
		logic        permitted;
	} rsp_t;

endpackage

### sv/segmented_memory_with_permissions_core.sv
// Byte-serial RAM with a four-segment permission check, APB permission registers.
//
//   channel   direction  handshake             payload
//   request   in         req_valid / req_stall req     (smp_pkg::req_t)
//   response  out        rsp_valid / rsp_stall rsp     (smp_pkg::rsp_t)
//   config    in/out     APB psel/penable      paddr, pwdata, prdata
//
// After the cycle that accepts it, a read of N bytes that meets no fault passes through
// S_ACCESS once per byte, then S_DRAIN and S_DONE, which loads the response; a write
// passes through S_ACCESS and S_DONE and a query through S_QUERY and S_DONE. One shared
// address adder and segment checker handles one byte per cycle, and the registered RAM
// read adds the drain state at the end of a read. A clear request sweeps the RAM one byte
// per cycle and then loads its response. After reset the same sweep runs before the first request.
// The response sits in its own register, so a new request is taken while an
// earlier response is still stalled; the block only waits at its end if that
// register is still occupied.
module segmented_memory_with_permissions_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  smp_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output smp_pkg::rsp_t                      rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [smp_pkg::APB_AW-1:0]         paddr,
	input  logic [smp_pkg::APB_DW-1:0]         pwdata,
	output logic [smp_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);

	// Control state.
	smp_pkg::state_t                state_q, state_d;
	logic [smp_pkg::MEM_AW-1:0]     clr_cnt_q;
	logic                           clr_rsp_q;
	logic                           rd_pend_q;
	logic                           rsp_valid_q;
	logic [smp_pkg::PERM_W-1:0]     perm_q [smp_pkg::NUM_SEGS];

	// Request being worked on.
	smp_pkg::op_t                   op_q;
	logic [1:0]                     size_q;
	logic [31:0]                    addr_q;
	logic [63:0]                    wdata_q;
	logic [2:0]                     qmask_q;
	logic [2:0]                     idx_q;
	logic [2:0]                     rd_idx_q;
	logic [63:0]                    rdata_q;
	logic [1:0]                     status_q;
	logic                           permitted_q;
	smp_pkg::rsp_t                  rsp_q;

	// RAM.
	logic [7:0]                     ram_q [smp_pkg::MEM_BYTES];
	logic [7:0]                     rd_byte_q;
	logic                           mem_we;
	logic [smp_pkg::MEM_AW-1:0]     mem_waddr;
	logic [7:0]                     mem_wdata;

	// Shared byte checker.
	logic [smp_pkg::BADDR_W-1:0]    byte_addr;
	logic [smp_pkg::PERM_W-1:0]     seg_mask;
	logic [smp_pkg::PERM_W-1:0]     chk_kind;
	logic [1:0]                     chk_stat;
	logic [2:0]                     last_idx;
	logic                           req_take;
	logic                           rsp_load;
	logic                           cfg_write;

	assign req_take  = req_valid && !req_stall;
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration registers: the mask index is the word address.
	assign pready = 1'b1;
	assign prdata = smp_pkg::APB_DW'(perm_q[paddr[smp_pkg::APB_AW-1:2]]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_q[0] <= smp_pkg::PERM_RST_CODE;
			perm_q[1] <= smp_pkg::PERM_RST_OTHER;
			perm_q[2] <= smp_pkg::PERM_RST_OTHER;
			perm_q[3] <= smp_pkg::PERM_RST_OTHER;
		end else if (cfg_write) begin
			perm_q[paddr[smp_pkg::APB_AW-1:2]] <= pwdata[smp_pkg::PERM_W-1:0];
		end
	end

	// The byte address is the base plus the byte offset, one bit wider than the
	// base so that an access running past the top of the 32-bit space is simply
	// out of memory.
	assign byte_addr = {1'b0, addr_q} + smp_pkg::BADDR_W'(idx_q);

	// The first segment that contains the address decides; an address in no
	// segment has no rights at all.
	always_comb begin
		priority if (byte_addr < smp_pkg::SEG_END_CODE) begin
			seg_mask = perm_q[0];
		end else if (byte_addr < smp_pkg::SEG_END_DATA) begin
			seg_mask = perm_q[1];
		end else if (byte_addr < smp_pkg::SEG_END_HEAP) begin
			seg_mask = perm_q[2];
		end else if (byte_addr >= smp_pkg::STACK_BASE && byte_addr < smp_pkg::STACK_END) begin
			seg_mask = perm_q[3];
		end else begin
			seg_mask = '0;
		end
	end

	// Reads need only the read bit and writes only the write bit. The range
	// check of a byte comes before its permission check.
	assign chk_kind = (op_q == smp_pkg::OP_READ) ? smp_pkg::PERM_READ : smp_pkg::PERM_WRITE;

	always_comb begin
		priority if (byte_addr >= smp_pkg::MEM_END) begin
			chk_stat = smp_pkg::STAT_INVALID;
		end else if ((seg_mask & chk_kind) == '0) begin
			chk_stat = smp_pkg::STAT_VIOLATION;
		end else begin
			chk_stat = smp_pkg::STAT_OK;
		end
	end

	always_comb begin
		unique case (size_q)
			2'd0: last_idx = 3'd0;
			2'd1: last_idx = 3'd1;
			2'd2: last_idx = 3'd3;
			default: last_idx = 3'd7;
		endcase
	end

	// Sequencer: next state, RAM write port and response load.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		rsp_load  = 1'b0;
		unique case (state_q)
			smp_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_cnt_q == smp_pkg::CLR_LAST) begin
					state_d = clr_rsp_q ? smp_pkg::S_DONE : smp_pkg::S_IDLE;
				end
			end
			smp_pkg::S_IDLE: begin
				if (req_valid) begin
					unique case (req.opcode)
						smp_pkg::OP_READ,
						smp_pkg::OP_WRITE: state_d = smp_pkg::S_ACCESS;
						smp_pkg::OP_QUERY: state_d = smp_pkg::S_QUERY;
						smp_pkg::OP_CLEAR: state_d = smp_pkg::S_CLEAR;
					endcase
				end
			end
			smp_pkg::S_ACCESS: begin
				if (chk_stat != smp_pkg::STAT_OK) begin
					// Bytes already written stay written; the failing byte is not.
					state_d = smp_pkg::S_DONE;
				end else begin
					if (op_q == smp_pkg::OP_WRITE) begin
						mem_we    = 1'b1;
						mem_waddr = byte_addr[smp_pkg::MEM_AW-1:0];
						mem_wdata = wdata_q[8*idx_q +: 8];
					end
					if (idx_q == last_idx) begin
						state_d = (op_q == smp_pkg::OP_READ) ? smp_pkg::S_DRAIN
						                                     : smp_pkg::S_DONE;
					end
				end
			end
			smp_pkg::S_QUERY: begin
				state_d = smp_pkg::S_DONE;
			end
			smp_pkg::S_DRAIN: begin
				state_d = smp_pkg::S_DONE;
			end
			smp_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = smp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = smp_pkg::S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != smp_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smp_pkg::S_CLEAR;
			clr_cnt_q   <= '0;
			clr_rsp_q   <= 1'b0;
			rd_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == smp_pkg::S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (req_take) begin
				clr_rsp_q <= (req.opcode == smp_pkg::OP_CLEAR);
				clr_cnt_q <= '0;
			end
			rd_pend_q <= (state_q == smp_pkg::S_ACCESS) && (op_q == smp_pkg::OP_READ) &&
			             (chk_stat == smp_pkg::STAT_OK);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request registers and result assembly.
	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q;
		if (rd_pend_q) begin
			rdata_q[8*rd_idx_q +: 8] <= rd_byte_q;
		end
		if (state_q == smp_pkg::S_ACCESS) begin
			if (chk_stat != smp_pkg::STAT_OK) begin
				status_q <= chk_stat;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (state_q == smp_pkg::S_QUERY) begin
			permitted_q <= |(seg_mask & qmask_q);
		end
		if (req_take) begin
			op_q        <= req.opcode;
			size_q      <= req.size_code;
			addr_q      <= req.address;
			wdata_q     <= req.write_data;
			qmask_q     <= req.query_mask;
			idx_q       <= '0;
			rdata_q     <= '0;
			status_q    <= smp_pkg::STAT_OK;
			permitted_q <= 1'b0;
		end
		if (rsp_load) begin
			// A failed read returns zero whatever bytes were fetched before the fault.
			rsp_q.read_data <= (status_q == smp_pkg::STAT_OK) ? rdata_q : '0;
			rsp_q.status    <= status_q;
			rsp_q.permitted <= permitted_q;
		end
	end

	// Byte RAM with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ram_q[mem_waddr] <= mem_wdata;
		end
		rd_byte_q <= ram_q[byte_addr[smp_pkg::MEM_AW-1:0]];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A response only appears after the sequencer has finished a request.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == smp_pkg::S_DONE))
		else $error("response raised outside the done state");

	// A faulted access never returns data.
	a_fault_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.status != smp_pkg::STAT_OK) |-> rsp_q.read_data == '0)
		else $error("faulted response carries read data");

	// No request is taken while the RAM sweep runs.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smp_pkg::S_CLEAR) |-> req_stall)
		else $error("request accepted during the clear sweep");

	// A read fetch is only pending right after a successful read byte.
	a_rd_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(state_q == smp_pkg::S_ACCESS) && $past(op_q == smp_pkg::OP_READ))
		else $error("read fetch pending without a read access");

endmodule
